FILE: sv/lrp_pkg.sv
// Package for the LRU replacer with pinning.
// Holds the field widths, operation codes and the cell entry and control types.
// No dependencies.
`default_nettype none

package lrp_pkg;

  localparam int unsigned FrameW        = 6;
  localparam int unsigned OpW           = 2;
  localparam int unsigned CountOutW     = 7;
  localparam int unsigned NumFramesDef  = 64;

  localparam logic [OpW-1:0] OpVictim = 2'd0;
  localparam logic [OpW-1:0] OpPin    = 2'd1;
  localparam logic [OpW-1:0] OpUnpin  = 2'd2;

  // One slot of the recency order.
  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
  } lrp_entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic              victim;
    logic              pin;
    logic              insert;
    logic [FrameW-1:0] frame;
  } lrp_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/lrp_cell.sv
// One slot of the recency chain for the LRU replacer.
// Depends on lrp_pkg for the entry and control types.
`default_nettype none

module lrp_cell
  import lrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire lrp_ctrl_t  ctrl_i,
  input  wire lrp_entry_t up_i,
  input  wire logic       prev_valid_i,
  input  wire logic       remove_i,
  output      lrp_entry_t entry_o,
  output      logic       hit_o,
  output      logic       remove_o
);

  logic              valid_q, valid_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic              shift;

  assign hit_o    = valid_q && (frame_q == ctrl_i.frame);
  assign remove_o = remove_i || (ctrl_i.pin && hit_o);
  // Every slot at or above the removed one takes its upper neighbor.
  assign shift    = ctrl_i.victim || remove_o;

  always_comb begin
    valid_d = valid_q;
    frame_d = frame_q;
    if (shift) begin
      valid_d = up_i.valid;
      frame_d = up_i.frame;
    end else if (ctrl_i.insert && !valid_q && prev_valid_i) begin
      // Valid slots form a prefix, so only the first free slot loads.
      valid_d = 1'b1;
      frame_d = ctrl_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  assign entry_o.valid = valid_q;
  assign entry_o.frame = frame_q;

endmodule

`default_nettype wire

FILE: sv/lru_replacer_with_pinning.sv
// LRU replacer with pinning: a chain of NUM_FRAMES cells holds the recency order.
// The result strobe comes in the cycle after start is taken.
// Throughput: one transaction per cycle; busy is never raised, since the whole
// chain shifts or loads in the cycle of the request and the receiver cannot stall.
// Reset empties the chain and clears the count; all frames read as absent.
// Depends on lrp_pkg and lrp_cell.
`default_nettype none

module lru_replacer_with_pinning
  import lrp_pkg::*;
#(
  parameter int unsigned NUM_FRAMES = NumFramesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic [OpW-1:0]       operation_i,
  input  wire logic [FrameW-1:0]    frame_i,
  output      logic                 done,
  output      logic                 victim_found_o,
  output      logic [FrameW-1:0]    victim_frame_o,
  output      logic [CountOutW-1:0] evictable_count_o
);

  localparam int unsigned CountW = $clog2(NUM_FRAMES + 1);

  lrp_entry_t        entry [NUM_FRAMES];
  lrp_entry_t        up    [NUM_FRAMES];
  logic              prev_valid [NUM_FRAMES];
  logic [NUM_FRAMES:0] remove;
  logic [NUM_FRAMES-1:0] hit;
  lrp_ctrl_t         ctrl;

  logic              go;
  logic              in_range;
  logic              any_hit;
  logic [CountW-1:0] len_q, len_d;
  logic              done_q;
  logic              found_q, found_d;
  logic [FrameW-1:0] vframe_q, vframe_d;
  logic [CountW+CountOutW-1:0] len_ext;

  assign busy     = 1'b0;
  assign go       = start && !busy;
  assign in_range = 32'(frame_i) < 32'(NUM_FRAMES);
  assign any_hit  = |hit;

  assign ctrl.victim = go && (operation_i == OpVictim);
  assign ctrl.pin    = go && (operation_i == OpPin);
  assign ctrl.insert = go && (operation_i == OpUnpin) && in_range && !any_hit &&
                       (len_q != CountW'(NUM_FRAMES));
  assign ctrl.frame  = frame_i;

  assign remove[0] = 1'b0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_valid[i] = 1'b1;
    end else begin : g_rest
      assign prev_valid[i] = entry[i-1].valid;
    end
    if (i == NUM_FRAMES - 1) begin : g_last
      assign up[i] = '0;
    end else begin : g_mid
      assign up[i] = entry[i+1];
    end

    lrp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .up_i        (up[i]),
      .prev_valid_i(prev_valid[i]),
      .remove_i    (remove[i]),
      .entry_o     (entry[i]),
      .hit_o       (hit[i]),
      .remove_o    (remove[i+1])
    );
  end

  always_comb begin
    len_d    = len_q;
    found_d  = 1'b0;
    vframe_d = '0;
    if (ctrl.victim && entry[0].valid) begin
      len_d    = len_q - CountW'(1);
      found_d  = 1'b1;
      vframe_d = entry[0].frame;
    end else if (remove[NUM_FRAMES]) begin
      len_d = len_q - CountW'(1);
    end else if (ctrl.insert) begin
      len_d = len_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      done_q <= go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      found_q  <= found_d;
      vframe_q <= vframe_d;
    end
  end

  assign len_ext           = {{CountOutW{1'b0}}, len_q};
  assign done              = done_q;
  assign victim_found_o    = found_q;
  assign victim_frame_o    = vframe_q;
  assign evictable_count_o = len_ext[CountOutW-1:0];

endmodule

`default_nettype wire
